// ----- design/aapr_pkg.sv -----
// package for the axis-angle point rotator: payload types, config struct,
// angle constants and the cordic arctangent table
// no dependencies
package aapr_pkg;

  // default number of cordic iterations
  localparam int DEF_CORDIC_STAGES = 16;

  // depth of the queue between front and back
  localparam int Q_DEPTH = 4;

  // number of back-end pipeline stages, output register included
  localparam int BACK_STAGES = 7;

  // number of modulo reduction steps (2pi times 2^18 down to 2pi times 1)
  localparam int RED_STEPS = 19;

  // angle constants, q.28 radians
  localparam logic signed [32:0] TWO_PI_Q28   = 33'sd1686629713;
  localparam logic signed [32:0] PI_Q28       = 33'sd843314857;
  localparam logic signed [32:0] HALF_PI_Q28  = 33'sd421657428;
  localparam logic signed [32:0] NHALF_PI_Q28 = -33'sd421657428;

  // cordic gain, q2.30
  localparam logic signed [33:0] CORDIC_K_Q30 = 34'sd652032874;

  // axis reset value, 1.0 in q2.16
  localparam logic signed [17:0] AXIS_ONE = 18'sd65536;

  // register indexes
  typedef enum logic [2:0] {
    REG_ORIGIN_X       = 3'd0,
    REG_ORIGIN_Y       = 3'd1,
    REG_ORIGIN_Z       = 3'd2,
    REG_AXIS_X         = 3'd3,
    REG_AXIS_Y         = 3'd4,
    REG_AXIS_Z         = 3'd5,
    REG_ANGLE_PER_STEP = 3'd6
  } reg_idx_t;

  typedef logic signed [31:0] coord_t;
  typedef logic signed [32:0] diff_t;
  typedef logic signed [17:0] axis_t;
  typedef logic signed [27:0] trig_t;

  // configuration register set
  typedef struct packed {
    coord_t origin_x;
    coord_t origin_y;
    coord_t origin_z;
    axis_t  axis_x;
    axis_t  axis_y;
    axis_t  axis_z;
    coord_t angle_per_step;
  } cfg_t;

  // item handed from front to back
  typedef struct packed {
    trig_t cs;
    trig_t sn;
    diff_t t_x;
    diff_t t_y;
    diff_t t_z;
  } fwd_t;

  // queue status between front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // atan(2^-i) in q.28, rounded to nearest
  function automatic logic signed [31:0] atan_q28(input int i);
    logic signed [31:0] a;
    case (i)
      0:       a = 32'sd210828714;
      1:       a = 32'sd124459457;
      2:       a = 32'sd65760959;
      3:       a = 32'sd33381290;
      4:       a = 32'sd16755422;
      5:       a = 32'sd8385879;
      6:       a = 32'sd4193963;
      7:       a = 32'sd2097109;
      8:       a = 32'sd1048571;
      9:       a = 32'sd524287;
      default: a = (i >= 28) ? 32'sd1 : (32'sd1 <<< (28 - i));
    endcase
    return a;
  endfunction

endpackage

// ----- design/aapr_if.sv -----
// channel interfaces of the rotator: point input, result output, config writes
// depends on aapr_pkg
interface aapr_in_if import aapr_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [15:0] step_count;
  coord_t      in_x;
  coord_t      in_y;
  coord_t      in_z;

  modport source (output valid, step_count, in_x, in_y, in_z, input ready);
  modport sink (input valid, step_count, in_x, in_y, in_z, output ready);
endinterface

interface aapr_out_if import aapr_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t out_x;
  coord_t out_y;
  coord_t out_z;
  logic   overflow;

  modport source (output valid, out_x, out_y, out_z, overflow, input ready);
  modport sink (input valid, out_x, out_y, out_z, overflow, output ready);
endinterface

interface aapr_cfg_if ();
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- design/aapr_front.sv -----
// front end: angle product, modulo 2pi reduction, quadrant fold, cordic
// pipeline and rounding of sine and cosine; carries p - o alongside
// depends on aapr_pkg
module aapr_front import aapr_pkg::*; #(
  parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [15:0] step_count,
  input  coord_t      in_x,
  input  coord_t      in_y,
  input  coord_t      in_z,
  input  cfg_t        cfg,
  output logic        out_valid,
  output fwd_t        out_data
);

  localparam int NST = CORDIC_STAGES;
  localparam int L   = RED_STEPS + NST + 3;
  localparam logic [48:0] RED_OFFSET = 49'(TWO_PI_Q28) << (RED_STEPS - 2);

  logic [L-1:0]       vld_r;
  diff_t              tx_r [L];
  diff_t              ty_r [L];
  diff_t              tz_r [L];
  logic signed [47:0] prod_r;
  logic [48:0]        red_in;
  logic [48:0]        red_r [1:RED_STEPS];
  logic signed [32:0] r0, r1;
  logic signed [31:0] z_nxt;
  logic               neg_nxt;
  logic signed [33:0] cx_r [NST+1];
  logic signed [33:0] cy_r [NST+1];
  logic signed [31:0] cz_r [NST+1];
  logic               cneg_r [NST+1];
  trig_t              cs_nxt, sn_nxt, cs_r, sn_r;

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[L-2:0], in_valid};
    end
  end

  // entry stage: angle product and offset from origin
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= 48'(cfg.angle_per_step) * 48'($signed({1'b0, step_count}));
      tx_r[0] <= 33'(in_x) - 33'(cfg.origin_x);
      ty_r[0] <= 33'(in_y) - 33'(cfg.origin_y);
      tz_r[0] <= 33'(in_z) - 33'(cfg.origin_z);
    end
  end

  // carry the offset vector down the pipe
  for (genvar k = 1; k < L; k++) begin : g_tpipe
    always_ff @(posedge clk) begin
      if (en) begin
        tx_r[k] <= tx_r[k-1];
        ty_r[k] <= ty_r[k-1];
        tz_r[k] <= tz_r[k-1];
      end
    end
  end

  // lift into non-negative range by a multiple of 2pi
  assign red_in = 49'(prod_r) + RED_OFFSET;

  // restoring reduction, one multiple of 2pi per stage
  for (genvar s = 0; s < RED_STEPS; s++) begin : g_red
    localparam logic [48:0] LIM = 49'(TWO_PI_Q28) << (RED_STEPS - 1 - s);
    logic [48:0] cur;
    if (s == 0) begin : g_first
      assign cur = red_in;
    end else begin : g_next
      assign cur = red_r[s];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        red_r[s+1] <= (cur >= LIM) ? cur - LIM : cur;
      end
    end
  end

  // map to [-pi, pi) and fold into [-pi/2, pi/2]
  always_comb begin
    r0 = $signed({2'b00, red_r[RED_STEPS][30:0]});
    r1 = (r0 >= PI_Q28) ? r0 - TWO_PI_Q28 : r0;
    neg_nxt = 1'b0;
    z_nxt = 32'(r1);
    if (r1 > HALF_PI_Q28) begin
      z_nxt = 32'(r1 - PI_Q28);
      neg_nxt = 1'b1;
    end else if (r1 < NHALF_PI_Q28) begin
      z_nxt = 32'(r1 + PI_Q28);
      neg_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r[0] <= CORDIC_K_Q30;
      cy_r[0] <= '0;
      cz_r[0] <= z_nxt;
      cneg_r[0] <= neg_nxt;
    end
  end

  // cordic rotation stages
  for (genvar i = 0; i < NST; i++) begin : g_cordic
    localparam logic signed [31:0] ATAN = atan_q28(i);
    always_ff @(posedge clk) begin
      if (en) begin
        if (cz_r[i] >= 0) begin
          cx_r[i+1] <= cx_r[i] - (cy_r[i] >>> i);
          cy_r[i+1] <= cy_r[i] + (cx_r[i] >>> i);
          cz_r[i+1] <= cz_r[i] - ATAN;
        end else begin
          cx_r[i+1] <= cx_r[i] + (cy_r[i] >>> i);
          cy_r[i+1] <= cy_r[i] - (cx_r[i] >>> i);
          cz_r[i+1] <= cz_r[i] + ATAN;
        end
        cneg_r[i+1] <= cneg_r[i];
      end
    end
  end

  // round q30 to q24 and undo the fold
  always_comb begin
    cs_nxt = 28'((cx_r[NST] + 34'sd32) >>> 6);
    sn_nxt = 28'((cy_r[NST] + 34'sd32) >>> 6);
    if (cneg_r[NST]) begin
      cs_nxt = -cs_nxt;
      sn_nxt = -sn_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cs_r <= cs_nxt;
      sn_r <= sn_nxt;
    end
  end

  assign out_valid    = vld_r[L-1];
  assign out_data.cs  = cs_r;
  assign out_data.sn  = sn_r;
  assign out_data.t_x = tx_r[L-1];
  assign out_data.t_y = ty_r[L-1];
  assign out_data.t_z = tz_r[L-1];

endmodule

// ----- design/aapr_queue.sv -----
// short fifo between the front and back ends
// depends on aapr_pkg
module aapr_queue import aapr_pkg::*; #(
  parameter int DEPTH = Q_DEPTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  fwd_t    push_data,
  input  logic    pop,
  output fwd_t    head,
  output q_stat_t stat
);

  localparam int AW = $clog2(DEPTH);

  fwd_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [AW:0]   cnt_r;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  assign head       = mem[rd_ptr_r];
  assign stat.full  = (cnt_r == (AW+1)'(DEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

// ----- design/aapr_back.sv -----
// back end: cross and dot products, rodrigues sum, rounding and saturation
// depends on aapr_pkg
module aapr_back import aapr_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  logic   in_valid,
  input  fwd_t   in_data,
  input  cfg_t   cfg,
  output logic   out_valid,
  output coord_t out_x,
  output coord_t out_y,
  output coord_t out_z,
  output logic   overflow
);

  logic [BACK_STAGES-1:0] bv_r;
  axis_t              k [3];
  diff_t              t [3];
  coord_t             o [3];
  logic signed [50:0] m_r [9];
  logic signed [60:0] cst_r [3];
  trig_t              cs1_r, sn1_r, cs2_r, sn2_r;
  logic signed [51:0] diff [3];
  logic signed [52:0] dsum;
  logic signed [35:0] cr_r [3];
  logic signed [36:0] dot_r;
  logic signed [52:0] cst8_r [3], cst8b_r [3], cst8c_r [3];
  logic signed [26:0] omc;
  logic signed [63:0] sncr_r [3];
  logic signed [62:0] dc_r;
  logic signed [55:0] sncr8_r [3];
  logic signed [38:0] c_r;
  logic signed [56:0] ck_r [3];
  logic signed [56:0] a_r [3];
  logic signed [59:0] s_r [3];
  logic signed [43:0] rs [3];
  coord_t             res_r [3];
  logic               ovf_r;
  logic [2:0]         sat;

  assign k[0] = cfg.axis_x;
  assign k[1] = cfg.axis_y;
  assign k[2] = cfg.axis_z;
  assign o[0] = cfg.origin_x;
  assign o[1] = cfg.origin_y;
  assign o[2] = cfg.origin_z;
  assign t[0] = in_data.t_x;
  assign t[1] = in_data.t_y;
  assign t[2] = in_data.t_z;

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r <= '0;
    end else if (en) begin
      bv_r <= {bv_r[BACK_STAGES-2:0], in_valid};
    end
  end

  // axis by offset products and cosine terms
  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0] <= 51'(k[1]) * 51'(t[2]);
      m_r[1] <= 51'(k[2]) * 51'(t[1]);
      m_r[2] <= 51'(k[2]) * 51'(t[0]);
      m_r[3] <= 51'(k[0]) * 51'(t[2]);
      m_r[4] <= 51'(k[0]) * 51'(t[1]);
      m_r[5] <= 51'(k[1]) * 51'(t[0]);
      m_r[6] <= 51'(k[0]) * 51'(t[0]);
      m_r[7] <= 51'(k[1]) * 51'(t[1]);
      m_r[8] <= 51'(k[2]) * 51'(t[2]);
      for (int i = 0; i < 3; i++) begin
        cst_r[i] <= 61'(in_data.cs) * 61'(t[i]);
      end
      cs1_r <= in_data.cs;
      sn1_r <= in_data.sn;
    end
  end

  // cross and dot combine, round to q.16
  always_comb begin
    diff[0] = 52'(m_r[0]) - 52'(m_r[1]);
    diff[1] = 52'(m_r[2]) - 52'(m_r[3]);
    diff[2] = 52'(m_r[4]) - 52'(m_r[5]);
    dsum    = 53'(m_r[6]) + 53'(m_r[7]) + 53'(m_r[8]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        cr_r[i]   <= 36'((diff[i] + 52'sd32768) >>> 16);
        cst8_r[i] <= 53'((cst_r[i] + 61'sd128) >>> 8);
      end
      dot_r <= 37'((dsum + 53'sd32768) >>> 16);
      cs2_r <= cs1_r;
      sn2_r <= sn1_r;
    end
  end

  // sine by cross, dot by one minus cosine (reaches 2.0 when cosine is -1)
  assign omc = 27'sd16777216 - 27'(cs2_r);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sncr_r[i]  <= 64'(sn2_r) * 64'(cr_r[i]);
        cst8b_r[i] <= cst8_r[i];
      end
      dc_r <= 63'(dot_r) * 63'(omc);
    end
  end

  // rounding of the second products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sncr8_r[i] <= 56'((sncr_r[i] + 64'sd128) >>> 8);
        cst8c_r[i] <= cst8b_r[i];
      end
      c_r <= 39'((dc_r + 63'sd8388608) >>> 24);
    end
  end

  // axial term and partial sum
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ck_r[i] <= 57'(c_r) * 57'(k[i]);
        a_r[i]  <= 57'(cst8c_r[i]) + 57'(sncr8_r[i]);
      end
    end
  end

  // full sum in q.32 with the origin added back
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s_r[i] <= 60'(a_r[i]) + 60'(ck_r[i]) + (60'(o[i]) <<< 16);
      end
    end
  end

  // round to q.16 and saturate
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rs[i]  = 44'((s_r[i] + 60'sd32768) >>> 16);
      sat[i] = (rs[i] > 44'sd2147483647) || (rs[i] < -44'sd2147483648);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (rs[i] > 44'sd2147483647) begin
          res_r[i] <= 32'sh7fffffff;
        end else if (rs[i] < -44'sd2147483648) begin
          res_r[i] <= 32'sh80000000;
        end else begin
          res_r[i] <= 32'(rs[i]);
        end
      end
      ovf_r <= |sat;
    end
  end

  assign out_valid = bv_r[BACK_STAGES-1];
  assign out_x     = res_r[0];
  assign out_y     = res_r[1];
  assign out_z     = res_r[2];
  assign overflow  = ovf_r;

endmodule

// ----- design/axis_angle_point_rotator_top.sv -----
// Rotates one Q16.16 point per beat about a configured unit axis through a
// configured origin by angle_per_step * step_count (Rodrigues' formula).
// One point is accepted every cycle while results are taken. An accepted
// input beat passes through the front (angle product, 19 modulo-2pi
// reduction steps, quadrant fold, one cordic stage per iteration, rounding),
// the queue and the 7 back stages (multiplier, rounding, sum and saturation
// stages) to reach its result. Configuration writes take effect for items
// accepted after them and must be made while the block is empty.
// depends on aapr_pkg, aapr_if, aapr_front, aapr_queue, aapr_back
module axis_angle_point_rotator_top import aapr_pkg::*; #(
  parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
  input  logic      clk,
  input  logic      rst_n,
  aapr_in_if.sink   in_if,
  aapr_out_if.source out_if,
  aapr_cfg_if.sink  cfg_if
);

  cfg_t    cfg_r;
  logic    en_f, en_b;
  logic    f_valid;
  fwd_t    f_data;
  fwd_t    q_head;
  q_stat_t q_stat;
  logic    push, pop;

  // configuration registers
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{origin_x: '0, origin_y: '0, origin_z: '0, axis_x: '0, axis_y: '0,
                 axis_z: AXIS_ONE, angle_per_step: '0};
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_ORIGIN_X:       cfg_r.origin_x <= cfg_if.data;
        REG_ORIGIN_Y:       cfg_r.origin_y <= cfg_if.data;
        REG_ORIGIN_Z:       cfg_r.origin_z <= cfg_if.data;
        REG_AXIS_X:         cfg_r.axis_x <= cfg_if.data[17:0];
        REG_AXIS_Y:         cfg_r.axis_y <= cfg_if.data[17:0];
        REG_AXIS_Z:         cfg_r.axis_z <= cfg_if.data[17:0];
        REG_ANGLE_PER_STEP: cfg_r.angle_per_step <= cfg_if.data;
        default: ;
      endcase
    end
  end

  // front advances unless its last beat is blocked by a full queue
  assign en_f        = !f_valid || !q_stat.full;
  assign in_if.ready = en_f;
  assign push        = f_valid && !q_stat.full;

  // back advances while the output register is free or being taken
  assign en_b = !out_if.valid || out_if.ready;
  assign pop  = en_b && !q_stat.empty;

  aapr_front #(.CORDIC_STAGES(CORDIC_STAGES)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en_f),
    .in_valid   (in_if.valid),
    .step_count (in_if.step_count),
    .in_x       (in_if.in_x),
    .in_y       (in_if.in_y),
    .in_z       (in_if.in_z),
    .cfg        (cfg_r),
    .out_valid  (f_valid),
    .out_data   (f_data)
  );

  aapr_queue #(.DEPTH(Q_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (f_data),
    .pop       (pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  aapr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en_b),
    .in_valid  (!q_stat.empty),
    .in_data   (q_head),
    .cfg       (cfg_r),
    .out_valid (out_if.valid),
    .out_x     (out_if.out_x),
    .out_y     (out_if.out_y),
    .out_z     (out_if.out_z),
    .overflow  (out_if.overflow)
  );

endmodule

// ----- design/aapr_checker.sv -----
// port-level checks for the rotator top, attached by bind
// no package dependencies
module aapr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_x,
  input logic [31:0] out_y,
  input logic [31:0] out_z,
  input logic        overflow,
  input logic        cfg_ready
);

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_x) && $stable(out_y) && $stable(out_z)
      && $stable(overflow))
    else $error("result payload changed while stalled");

  // pipeline comes out of reset empty and open
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("not empty after reset");

  // config port never back-pressures
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("config port not ready");

endmodule

bind axis_angle_point_rotator_top aapr_checker u_aapr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_x     (out_if.out_x),
  .out_y     (out_if.out_y),
  .out_z     (out_if.out_z),
  .overflow  (out_if.overflow),
  .cfg_ready (cfg_if.ready)
);

// ----- tb/tb_axis_angle_point_rotator_top.sv -----
// testbench for the axis-angle point rotator: directed and random points
// under several origin/axis/angle settings, checked against a local predictor
// depends on aapr_pkg, aapr_if and axis_angle_point_rotator_top
module tb_axis_angle_point_rotator_top;
  import aapr_pkg::*;

  localparam int STAGES = 16;
  localparam int DRAIN_CYCLES = 80;
  localparam int NUM_REGS = 7;
  localparam logic [2:0] REG_UNKNOWN = 3'd7;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        ovf;
  } point_res_t;

  // rotation predictor and queue of expected points
  class rotation_scoreboard;
    logic [31:0] regs [NUM_REGS];
    longint      atan_tab [30];
    point_res_t  pending_q [$];
    int          mismatches;
    int          checked;
    int          n_ovf;

    function new();
      longint unsigned sum, term;
      for (int i = 0; i < 30; i++) begin
        if (i == 0) begin
          atan_tab[i] = 210828714;
        end else begin
          sum = 0;
          for (int n = 0; (2 * n + 1) * i <= 60; n++) begin
            term = (64'd1 << (60 - (2 * n + 1) * i)) / longint'(2 * n + 1);
            if (n & 1) sum -= term;
            else sum += term;
          end
          atan_tab[i] = longint'((sum + (64'd1 << 31)) >> 32);
        end
      end
      for (int i = 0; i < NUM_REGS; i++) regs[i] = '0;
      regs[REG_AXIS_Z] = 32'd65536;
      mismatches = 0;
      checked = 0;
      n_ovf = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      if (idx < NUM_REGS) regs[idx] = val;
    endfunction

    function longint rnd(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    // rodrigues rotation in the block's fixed-point formats
    function void note_point(logic [15:0] steps, logic [31:0] px, logic [31:0] py,
                             logic [31:0] pz);
      longint o [3], k [3], p [3], t [3], cr [3];
      longint r, cx, cy, zz, dx, dy, cs, sn, dot, c, s, v;
      logic [31:0] res [3];
      bit neg, ovf;
      point_res_t e;
      neg = 0;
      ovf = 0;
      p[0] = longint'($signed(px));
      p[1] = longint'($signed(py));
      p[2] = longint'($signed(pz));
      for (int i = 0; i < 3; i++) begin
        o[i] = longint'($signed(regs[i]));
        k[i] = longint'($signed(regs[3 + i][17:0]));
        t[i] = p[i] - o[i];
      end
      // angle reduction into [-pi/2, pi/2] with sign fold
      r = longint'($signed(regs[REG_ANGLE_PER_STEP])) * longint'({48'd0, steps});
      r = r % longint'(TWO_PI_Q28);
      if (r < 0) r += longint'(TWO_PI_Q28);
      if (r >= longint'(PI_Q28)) r -= longint'(TWO_PI_Q28);
      if (r > longint'(HALF_PI_Q28)) begin
        r -= longint'(PI_Q28);
        neg = 1;
      end else if (r < -longint'(HALF_PI_Q28)) begin
        r += longint'(PI_Q28);
        neg = 1;
      end
      // cordic rotation mode
      cx = 652032874;
      cy = 0;
      zz = r;
      for (int i = 0; i < STAGES && i < 30; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (zz >= 0) begin
          cx -= dx; cy += dy; zz -= atan_tab[i];
        end else begin
          cx += dx; cy -= dy; zz += atan_tab[i];
        end
      end
      cs = rnd(cx, 6);
      sn = rnd(cy, 6);
      if (neg) begin
        cs = -cs;
        sn = -sn;
      end
      cr[0] = rnd(k[1] * t[2] - k[2] * t[1], 16);
      cr[1] = rnd(k[2] * t[0] - k[0] * t[2], 16);
      cr[2] = rnd(k[0] * t[1] - k[1] * t[0], 16);
      dot = rnd(t[0] * k[0] + t[1] * k[1] + t[2] * k[2], 16);
      c = rnd(dot * ((longint'(1) << 24) - cs), 24);
      for (int i = 0; i < 3; i++) begin
        s = rnd(cs * t[i], 8) + rnd(sn * cr[i], 8) + c * k[i] + o[i] * 65536;
        v = rnd(s, 16);
        if (v > 64'sd2147483647) begin
          v = 64'sd2147483647; ovf = 1;
        end else if (v < -64'sd2147483648) begin
          v = -64'sd2147483648; ovf = 1;
        end
        res[i] = v[31:0];
      end
      e.x = res[0];
      e.y = res[1];
      e.z = res[2];
      e.ovf = ovf;
      pending_q.push_back(e);
    endfunction

    function void check_point(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                              logic aovf);
      point_res_t e;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: %h %h %h ovf=%b", ax, ay, az, aovf);
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (e.ovf) n_ovf++;
      if (ax !== e.x || ay !== e.y || az !== e.z || aovf !== e.ovf) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch #%0d: exp %h %h %h ovf=%b, got %h %h %h ovf=%b",
                   checked, e.x, e.y, e.z, e.ovf, ax, ay, az, aovf);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  aapr_in_if  in_if ();
  aapr_out_if out_if ();
  aapr_cfg_if cfg_if ();

  rotation_scoreboard sb;
  bit hold_req;
  int n_sent;
  int n_phases;

  axis_angle_point_rotator_top #(.CORDIC_STAGES(STAGES)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if.sink),
    .out_if (out_if.source),
    .cfg_if (cfg_if.sink)
  );

  // clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // run limit
  initial begin
    #(12 * 600000);
    $display("Some tests failed");
    $finish;
  end

  // result beats
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_point(out_if.out_x, out_if.out_y, out_if.out_z, out_if.overflow);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_if.ready = 1'b0;
        repeat (250) @(negedge clk);
        hold_req = 0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_if.ready = 1'b0;
        repeat (pick_gap()) @(negedge clk);
      end
      out_if.ready = 1'b1;
      repeat ($urandom_range(0, 1) ? $urandom_range(0, 40) : 0) @(negedge clk);
    end
  end

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_point(logic [15:0] steps, logic [31:0] px, logic [31:0] py,
                            logic [31:0] pz, int gap);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.step_count = steps;
    in_if.in_x = px;
    in_if.in_y = py;
    in_if.in_z = pz;
    in_if.valid = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    sb.note_point(steps, px, py, pz);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_if.index = idx;
    cfg_if.data = val;
    cfg_if.valid = 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // wait until every expected result has arrived, then let the pipe empty
  task automatic drain();
    int waited;
    in_if.valid = 1'b0;
    waited = 0;
    while (sb.pending_q.size() != 0) begin
      @(negedge clk);
      waited++;
      if (waited > 20000) begin
        $display("Some tests failed");
        $finish;
      end
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      2: return 32'($signed($urandom_range(0, 20000000)) - 10000000);
      default: return 32'($signed($urandom_range(0, 400)) - 200) <<< 16;
    endcase
  endfunction

  function automatic logic [15:0] rand_steps();
    case ($urandom_range(0, 4))
      0: return 16'd1;
      1: return 16'd0;
      2: return 16'($urandom_range(0, 16));
      default: return 16'($urandom());
    endcase
  endfunction

  // unit axis from random direction, upper data bits random noise
  task automatic set_unit_axis();
    real ax, ay, az, len;
    logic [17:0] q [3];
    do begin
      ax = real'($urandom_range(0, 2000)) - 1000.0;
      ay = real'($urandom_range(0, 2000)) - 1000.0;
      az = real'($urandom_range(0, 2000)) - 1000.0;
      len = $sqrt(ax * ax + ay * ay + az * az);
    end while (len < 1.0);
    q[0] = 18'($rtoi(ax / len * 65536.0));
    q[1] = 18'($rtoi(ay / len * 65536.0));
    q[2] = 18'($rtoi(az / len * 65536.0));
    write_reg(REG_AXIS_X, {14'($urandom()), q[0]});
    write_reg(REG_AXIS_Y, {14'($urandom()), q[1]});
    write_reg(REG_AXIS_Z, {14'($urandom()), q[2]});
  endtask

  task automatic random_points(int count);
    for (int i = 0; i < count; i++)
      send_point(rand_steps(), rand_coord(), rand_coord(), rand_coord(), pick_gap());
  endtask

  initial begin
    sb = new();
    hold_req = 0;
    n_sent = 0;
    n_phases = 0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.step_count = '0;
    in_if.in_x = '0;
    in_if.in_y = '0;
    in_if.in_z = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: reset settings, field extremes, zero step, identity axis
    send_point(16'd0, 32'h7fffffff, 32'h80000000, 32'h0, 0);
    send_point(16'd1, 32'h80000000, 32'h7fffffff, 32'hffffffff, 0);
    send_point(16'hffff, 32'h00010000, 32'hffff0000, 32'h7fffffff, 1);
    drain();
    write_reg(REG_ANGLE_PER_STEP, 32'sd421657428);
    write_reg(REG_UNKNOWN, 32'hdeadbeef);
    send_point(16'd1, 32'h00010000, 32'h0, 32'h0, 0);
    send_point(16'd2, 32'h00010000, 32'h00020000, 32'h0, 0);
    send_point(16'd3, 32'h7fffffff, 32'h7fffffff, 32'h0, 0);
    send_point(16'd0, 32'h12345678, 32'h87654321, 32'h0, 0);
    send_point(16'hffff, 32'h80000000, 32'h80000000, 32'h80000000, 0);
    drain();
    // angle extremes and fold boundaries
    write_reg(REG_ANGLE_PER_STEP, 32'h7fffffff);
    send_point(16'd1, 32'h7fffffff, 32'h0, 32'h0, 0);
    send_point(16'hffff, 32'h0, 32'h80000000, 32'h0, 0);
    drain();
    write_reg(REG_ANGLE_PER_STEP, 32'h80000000);
    send_point(16'd1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0);
    send_point(16'hffff, 32'h40000000, 32'hc0000000, 32'h0, 0);
    drain();
    write_reg(REG_ANGLE_PER_STEP, 32'sd843314857);
    send_point(16'd1, 32'h7fff0000, 32'h0, 32'h0, 0);
    send_point(16'd2, 32'h7fff0000, 32'h1, 32'h0, 0);
    drain();
    // axis extremes, non-unit axis, origin extremes
    write_reg(REG_AXIS_X, 32'h0001ffff);
    write_reg(REG_AXIS_Y, 32'h00020000);
    write_reg(REG_AXIS_Z, 32'h0001ffff);
    write_reg(REG_ORIGIN_X, 32'h7fffffff);
    write_reg(REG_ORIGIN_Y, 32'h80000000);
    write_reg(REG_ORIGIN_Z, 32'h7fffffff);
    write_reg(REG_ANGLE_PER_STEP, 32'sd123456789);
    send_point(16'd1, 32'h80000000, 32'h7fffffff, 32'h80000000, 0);
    send_point(16'd0, 32'h0, 32'h0, 32'h0, 0);
    send_point(16'd7, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0);
    send_point(16'hffff, 32'h80000000, 32'h80000000, 32'h80000000, 0);
    drain();

    // random phases, each with its own setting
    for (int ph = 0; ph < 9; ph++) begin
      n_phases++;
      case (ph)
        0: begin
          write_reg(REG_ORIGIN_X, 32'h0);
          write_reg(REG_ORIGIN_Y, 32'h0);
          write_reg(REG_ORIGIN_Z, 32'h0);
          write_reg(REG_AXIS_X, 32'h0);
          write_reg(REG_AXIS_Y, 32'h0);
          write_reg(REG_AXIS_Z, 32'h00010000);
          write_reg(REG_ANGLE_PER_STEP, 32'sd26353589);
        end
        1: begin
          write_reg(REG_AXIS_X, 32'hfffe0000);
          write_reg(REG_AXIS_Y, 32'h0);
          write_reg(REG_AXIS_Z, 32'h0);
          write_reg(REG_ANGLE_PER_STEP, 32'h80000000);
        end
        2: begin
          write_reg(REG_ORIGIN_X, 32'h80000000);
          write_reg(REG_ORIGIN_Y, 32'h7fffffff);
          write_reg(REG_ORIGIN_Z, 32'h80000000);
          write_reg(REG_ANGLE_PER_STEP, 32'h7fffffff);
        end
        3: begin
          for (int r = 0; r < 3; r++)
            write_reg(3'(REG_ORIGIN_X + r), 32'($signed($urandom_range(0, 200)) - 100) <<< 16);
          write_reg(REG_ANGLE_PER_STEP, $urandom());
          write_reg(REG_UNKNOWN, $urandom());
        end
        default: begin
          for (int r = 0; r < 3; r++)
            write_reg(3'(REG_ORIGIN_X + r), rand_coord());
          write_reg(REG_ANGLE_PER_STEP, $urandom());
        end
      endcase
      if (ph >= 3 && ph != 7) set_unit_axis();
      if (ph == 7) begin
        // raw non-unit axis
        write_reg(REG_AXIS_X, $urandom());
        write_reg(REG_AXIS_Y, $urandom());
        write_reg(REG_AXIS_Z, $urandom());
      end
      if (ph == 4) begin
        // receiver holds off while points keep coming back to back
        hold_req = 1;
        for (int i = 0; i < 60; i++)
          send_point(rand_steps(), rand_coord(), rand_coord(), rand_coord(), 0);
        random_points(40);
      end else begin
        random_points(100);
      end
      drain();
    end

    $display("covered %0d points, %0d results checked (%0d saturated), %0d random settings",
             n_sent, sb.checked, sb.n_ovf, n_phases);
    if (sb.mismatches > 0) $display("%0d mismatches in total", sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/aapr_pkg.sv
design/aapr_if.sv
design/aapr_front.sv
design/aapr_queue.sv
design/aapr_back.sv
design/axis_angle_point_rotator_top.sv
design/aapr_checker.sv
tb/tb_axis_angle_point_rotator_top.sv
